[src/assert_macros.svh]
// Assertion macros shared by the calibrator RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Plain invariant that must hold at every clock edge.
`define GBSC_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Implication checked at every clock edge.
`define GBSC_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

[src/gbsc_pkg.sv]
// Package for the gyro bias calibrator: sizes, codes, shared types and helpers.
// No dependencies.
package gbsc_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int FRAC_BITS   = 4;

  localparam int AW      = $clog2(MAX_SAMPLES);
  localparam int CNT_W   = AW + 1;
  localparam int RAW_W   = 16;
  localparam int SMP_W   = 3 * RAW_W;
  localparam int VAL_W   = 21;
  localparam int SC_W    = 11;
  localparam int CLIP_W  = 12;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 12;
  localparam int S_W     = RAW_W + AW;
  localparam int Q_W     = 2 * RAW_W - 1 + AW;
  localparam int NQ_W    = 2 * RAW_W - 1 + 2 * AW;
  localparam int CLIP2_W = 2 * CLIP_W;
  localparam int LIM_W   = CLIP2_W + NQ_W;
  localparam int CMP_W   = 80;
  localparam int D_W     = RAW_W + AW + 2;
  localparam int DVD_W   = S_W + FRAC_BITS + 1;
  localparam int DVS_W   = CNT_W + 1;
  localparam int WIDE_W  = DVD_W + 1;
  localparam int MUL_W   = 32;

  localparam logic [CLIP_W-1:0]    CLIP_FLOOR = CLIP_W'(26);
  localparam logic [CFG_IDX_W-1:0] IDX_SAMPLE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] IDX_CLIP_SIGMA   = CFG_IDX_W'(1);
  localparam logic [SC_W-1:0]      SC_RESET   = SC_W'(1000);
  localparam logic [CLIP_W-1:0]    CLIP_RESET = CLIP_W'(768);

  localparam logic signed [WIDE_W-1:0] VAL_HI = WIDE_W'(2 ** (VAL_W - 1) - 1);
  localparam logic signed [WIDE_W-1:0] VAL_LO = WIDE_W'(-(2 ** (VAL_W - 1)));

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > VAL_HI) r = VAL_HI[VAL_W-1:0];
    else if (v < VAL_LO) r = VAL_LO[VAL_W-1:0];
    else r = v[VAL_W-1:0];
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] corr_val(input logic signed [RAW_W-1:0] raw,
                                                        input logic signed [VAL_W-1:0] bias);
    logic signed [WIDE_W-1:0] w;
    w = (WIDE_W'(raw) <<< FRAC_BITS) - WIDE_W'(bias);
    return sat_val(w);
  endfunction

  function automatic logic signed [RAW_W-1:0] axis_val(input logic [SMP_W-1:0] w,
                                                        input logic [1:0] ax);
    logic signed [RAW_W-1:0] r;
    unique case (ax)
      2'd0:    r = w[RAW_W-1:0];
      2'd1:    r = w[2*RAW_W-1:RAW_W];
      default: r = w[3*RAW_W-1:2*RAW_W];
    endcase
    return r;
  endfunction

endpackage

[src/gbsc_store.sv]
// Sample store: one write port, one registered read port.
// Depends on gbsc_pkg.
module gbsc_store
  import gbsc_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [SMP_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [SMP_W-1:0] rdata_r
);

  logic [SMP_W-1:0] mem [MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

[src/gbsc_mul.sv]
// Shared unsigned multiplier with a registered product.
// Depends on gbsc_pkg.
module gbsc_mul
  import gbsc_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic [2*MUL_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

[src/gbsc_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on gbsc_pkg.
module gbsc_div
  import gbsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_r[DVS_W-1:0], dvd_r[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W);
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? shifted - {1'b0, dvs_r} : shifted;
        dvd_r <= {dvd_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = dvd_r;

endmodule

[src/gyro_bias_sigma_clip_calibrator.sv]
// Gyro bias calibrator with sigma clipping: sequencer, datapath and output register.
// Depends on gbsc_pkg, gbsc_store, gbsc_mul, gbsc_div and assert_macros.svh.
//
// Usage:
//   Input transactions (in_valid/in_stall) carry one three-axis raw sample.
//   Result transactions (out_valid/out_stall) carry a kind bit, three values
//   with FRAC_BITS fractional bits and a final_of_run flag.
//   The first sample_count samples are stored and give no result, except the
//   last one, which starts the bias run and then yields a bias record followed
//   by the corrected sample. Afterwards each sample gives one corrected result.
//   Throughput after calibration: one transaction per cycle while out_stall is
//   low; the result appears in the output register in the cycle after acceptance.
//   The bias run uses one shared multiplier and a bit-serial divider; per axis
//   it runs a sums pass, the variance and limit steps, a clip pass and the
//   mean division, and in_stall stays high for the whole run.
//   Reset (rst_n low, synchronous) clears the count, the calibrated flag and
//   the output valid flag and restores the register defaults. While out_stall is
//   high the result holds and no new transaction is accepted once it is full.
`include "assert_macros.svh"
module gyro_bias_sigma_clip_calibrator
  import gbsc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [RAW_W-1:0]     in_rate_x,
  input  logic signed [RAW_W-1:0]     in_rate_y,
  input  logic signed [RAW_W-1:0]     in_rate_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_result_kind,
  output logic signed [VAL_W-1:0]     out_value_x,
  output logic signed [VAL_W-1:0]     out_value_y,
  output logic signed [VAL_W-1:0]     out_value_z,
  output logic                        out_final_of_run
);

  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_P1_RD    = 19'h00002,
    ST_P1_SQ    = 19'h00004,
    ST_P1_ACC   = 19'h00008,
    ST_V0       = 19'h00010,
    ST_V1       = 19'h00020,
    ST_V2       = 19'h00040,
    ST_V3       = 19'h00080,
    ST_V4       = 19'h00100,
    ST_V5       = 19'h00200,
    ST_V6       = 19'h00400,
    ST_P2_RD    = 19'h00800,
    ST_P2_MUL   = 19'h01000,
    ST_P2_DM    = 19'h02000,
    ST_P2_CMP   = 19'h04000,
    ST_DIV_GO   = 19'h08000,
    ST_DIV_WAIT = 19'h10000,
    ST_BIAS     = 19'h20000,
    ST_EMIT2    = 19'h40000
  } state_t;

  state_t                  state_r;
  logic [SC_W-1:0]         sample_count_r;
  logic [CLIP_W-1:0]       clip_sigma_r;
  logic [CNT_W-1:0]        taken_r;
  logic                    calib_r;
  logic [CNT_W-1:0]        n_r;
  logic [CNT_W-1:0]        idx_r;
  logic [1:0]              ax_r;
  logic signed [S_W-1:0]   s_r;
  logic [Q_W-1:0]          q_r;
  logic [NQ_W-1:0]         nq_r;
  logic [NQ_W-1:0]         var_r;
  logic [CLIP2_W-1:0]      clip2_r;
  logic [LIM_W-1:0]        lim_r;
  logic signed [S_W-1:0]   ksum_r;
  logic [CNT_W-1:0]        kcnt_r;
  logic                    neg_r;
  logic signed [VAL_W-1:0] bias_r [3];
  logic signed [RAW_W-1:0] raw_r [3];
  logic                    out_valid_r;
  logic                    out_kind_r;
  logic                    out_fin_r;
  logic signed [VAL_W-1:0] out_x_r;
  logic signed [VAL_W-1:0] out_y_r;
  logic signed [VAL_W-1:0] out_z_r;

  logic                    out_free;
  logic                    out_load;
  logic                    in_acc;
  logic [CNT_W-1:0]        n_eff;
  logic [CNT_W-1:0]        taken_inc;
  logic                    store_we;
  logic [SMP_W-1:0]        rd_data;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic [2*MUL_W-1:0]      mul_p;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic signed [RAW_W-1:0] v;
  logic [RAW_W-1:0]        v_mag;
  logic [S_W-1:0]          s_mag;
  logic [CLIP_W-1:0]       clip;
  logic signed [D_W-1:0]   nv;
  logic signed [D_W-1:0]   dd;
  logic [D_W-1:0]          dm;
  logic                    use_k;
  logic signed [S_W-1:0]   num;
  logic [CNT_W-1:0]        den;
  logic [S_W-1:0]          num_mag;
  logic signed [WIDE_W-1:0] qw;
  logic signed [WIDE_W-1:0] bw;
  logic                    kept;
  logic                    last_idx;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = ((state_r == ST_IDLE) && in_acc && calib_r) || (state_r == ST_BIAS) ||
                     ((state_r == ST_EMIT2) && out_free);
  assign taken_inc = taken_r + CNT_W'(taken_r < CNT_W'(MAX_SAMPLES));
  assign store_we  = in_acc && !calib_r && (taken_r < CNT_W'(MAX_SAMPLES));
  assign last_idx  = (idx_r + CNT_W'(1)) == n_r;

  always_comb begin
    if (32'(sample_count_r) > MAX_SAMPLES) n_eff = CNT_W'(MAX_SAMPLES);
    else if (sample_count_r == '0) n_eff = CNT_W'(1);
    else n_eff = CNT_W'(sample_count_r);
  end

  assign clip  = (clip_sigma_r < CLIP_FLOOR) ? CLIP_FLOOR : clip_sigma_r;
  assign v     = axis_val(rd_data, ax_r);
  assign v_mag = v[RAW_W-1] ? RAW_W'(-v) : RAW_W'(v);
  assign s_mag = s_r[S_W-1] ? S_W'(-s_r) : S_W'(s_r);
  assign nv    = v[RAW_W-1] ? -signed'(mul_p[D_W-1:0]) : signed'(mul_p[D_W-1:0]);
  assign dd    = nv - D_W'(s_r);
  assign dm    = dd[D_W-1] ? D_W'(-dd) : D_W'(dd);
  assign kept  = {mul_p, 16'b0} <= CMP_W'(lim_r);

  assign use_k   = kcnt_r != '0;
  assign num     = use_k ? ksum_r : s_r;
  assign den     = use_k ? kcnt_r : n_r;
  assign num_mag = num[S_W-1] ? S_W'(-num) : S_W'(num);
  assign qw      = signed'(WIDE_W'(div_rsp.quo));
  assign bw      = neg_r ? -qw : qw;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_req.start    = 1'b0;
    div_req.dividend = (DVD_W'(num_mag) << (FRAC_BITS + 1)) + DVD_W'(den);
    div_req.divisor  = {den, 1'b0};
    unique case (state_r)
      ST_P1_SQ: begin
        mul_a = MUL_W'(v_mag);
        mul_b = MUL_W'(v_mag);
      end
      ST_V0: begin
        mul_a = MUL_W'(n_r);
        mul_b = q_r[31:0];
      end
      ST_V1: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(q_r[Q_W-1:32]);
      end
      ST_V2: begin
        mul_a = MUL_W'(s_mag);
        mul_b = MUL_W'(s_mag);
      end
      ST_V3: begin
        mul_a = MUL_W'(clip);
        mul_b = MUL_W'(clip);
      end
      ST_V4: begin
        mul_a = MUL_W'(mul_p[CLIP2_W-1:0]);
        mul_b = var_r[31:0];
      end
      ST_V5: begin
        mul_a = MUL_W'(clip2_r);
        mul_b = MUL_W'(var_r[NQ_W-1:32]);
      end
      ST_P2_MUL: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(v_mag);
      end
      ST_P2_DM: begin
        mul_a = MUL_W'(dm);
        mul_b = MUL_W'(dm);
      end
      ST_DIV_GO: begin
        div_req.start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  gbsc_store u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (taken_r[AW-1:0]),
    .wdata   ({in_rate_z, in_rate_y, in_rate_x}),
    .raddr   (idx_r[AW-1:0]),
    .rdata_r (rd_data)
  );

  gbsc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  gbsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= SC_RESET;
      clip_sigma_r   <= CLIP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == IDX_SAMPLE_COUNT) sample_count_r <= cfg_data[SC_W-1:0];
      else if (cfg_index == IDX_CLIP_SIGMA) clip_sigma_r <= cfg_data[CLIP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      taken_r     <= '0;
      calib_r     <= 1'b0;
      out_valid_r <= 1'b0;
      ax_r        <= '0;
      idx_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            raw_r[0] <= in_rate_x;
            raw_r[1] <= in_rate_y;
            raw_r[2] <= in_rate_z;
            if (calib_r) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= 1'b1;
              out_fin_r   <= 1'b1;
              out_x_r     <= corr_val(in_rate_x, bias_r[0]);
              out_y_r     <= corr_val(in_rate_y, bias_r[1]);
              out_z_r     <= corr_val(in_rate_z, bias_r[2]);
            end else begin
              taken_r <= taken_inc;
              if (taken_inc >= n_eff) begin
                n_r     <= taken_inc;
                ax_r    <= '0;
                idx_r   <= '0;
                s_r     <= '0;
                q_r     <= '0;
                state_r <= ST_P1_RD;
              end
            end
          end
        end
        ST_P1_RD: state_r <= ST_P1_SQ;
        ST_P1_SQ: begin
          s_r     <= s_r + S_W'(v);
          state_r <= ST_P1_ACC;
        end
        ST_P1_ACC: begin
          q_r   <= q_r + Q_W'(mul_p);
          idx_r <= idx_r + CNT_W'(1);
          state_r <= last_idx ? ST_V0 : ST_P1_RD;
        end
        ST_V0: state_r <= ST_V1;
        ST_V1: begin
          nq_r    <= NQ_W'(mul_p);
          state_r <= ST_V2;
        end
        ST_V2: begin
          nq_r    <= nq_r + {mul_p[NQ_W-33:0], 32'b0};
          state_r <= ST_V3;
        end
        ST_V3: begin
          var_r   <= nq_r - NQ_W'(mul_p);
          state_r <= ST_V4;
        end
        ST_V4: begin
          clip2_r <= mul_p[CLIP2_W-1:0];
          state_r <= ST_V5;
        end
        ST_V5: begin
          lim_r   <= LIM_W'(mul_p);
          state_r <= ST_V6;
        end
        ST_V6: begin
          lim_r   <= lim_r + {mul_p[LIM_W-33:0], 32'b0};
          idx_r   <= '0;
          ksum_r  <= '0;
          kcnt_r  <= '0;
          state_r <= ST_P2_RD;
        end
        ST_P2_RD:  state_r <= ST_P2_MUL;
        ST_P2_MUL: state_r <= ST_P2_DM;
        ST_P2_DM:  state_r <= ST_P2_CMP;
        ST_P2_CMP: begin
          if (kept) begin
            ksum_r <= ksum_r + S_W'(v);
            kcnt_r <= kcnt_r + CNT_W'(1);
          end
          idx_r   <= idx_r + CNT_W'(1);
          state_r <= last_idx ? ST_DIV_GO : ST_P2_RD;
        end
        ST_DIV_GO: begin
          neg_r   <= num[S_W-1];
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            bias_r[ax_r] <= sat_val(bw);
            if (ax_r == 2'd2) begin
              state_r <= ST_BIAS;
            end else begin
              ax_r    <= ax_r + 2'd1;
              idx_r   <= '0;
              s_r     <= '0;
              q_r     <= '0;
              state_r <= ST_P1_RD;
            end
          end
        end
        ST_BIAS: begin
          out_valid_r <= 1'b1;
          out_kind_r  <= 1'b0;
          out_fin_r   <= 1'b0;
          out_x_r     <= bias_r[0];
          out_y_r     <= bias_r[1];
          out_z_r     <= bias_r[2];
          state_r     <= ST_EMIT2;
        end
        ST_EMIT2: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= 1'b1;
            out_fin_r   <= 1'b1;
            out_x_r     <= corr_val(raw_r[0], bias_r[0]);
            out_y_r     <= corr_val(raw_r[1], bias_r[1]);
            out_z_r     <= corr_val(raw_r[2], bias_r[2]);
            calib_r     <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_final_of_run = out_fin_r;
  assign out_value_x      = out_x_r;
  assign out_value_y      = out_y_r;
  assign out_value_z      = out_z_r;

  `GBSC_IMPLY(a_busy_stalls, state_r != ST_IDLE, in_stall, "input accepted during bias run")
  `GBSC_CHECK(a_calib_holds, !$fell(calib_r), "calibrated flag dropped")
  `GBSC_CHECK(a_taken_cap, taken_r <= CNT_W'(MAX_SAMPLES), "sample count past store depth")
  `GBSC_IMPLY(a_bias_not_final, out_valid && !out_result_kind, !out_final_of_run,
              "bias record flagged final")

endmodule
